### rtl/fbrp_pkg.sv
`timescale 1ns / 1ps

package fbrp_pkg;

  localparam int RateW    = 25;
  localparam int FbRateW  = 24;
  localparam int TimeW    = 64;
  localparam int Word32W  = 32;
  localparam int DelayW   = 30;
  localparam int CfgIdxW  = 3;
  localparam int InDataW  = 120;
  localparam int OutDataW = 128;

  localparam logic [DelayW-1:0]  NsPerSec = DelayW'(1000000000);

  localparam logic [RateW-1:0]   FallbackRateRst = RateW'(100);
  localparam logic [RateW-1:0]   MinTxRateRst    = RateW'(10);
  localparam logic [Word32W-1:0] WarmupCountRst  = Word32W'(20);
  localparam logic [Word32W-1:0] LatencyLimitRst = Word32W'(10000);
  localparam logic [Word32W-1:0] NodeIdRst       = Word32W'(0);

  // Delay for the reset rate, worked out at elaboration.
  localparam int DelayRstInt = 1000000000 / 100;
  localparam logic [DelayW-1:0] DelayRst = DelayW'(DelayRstInt);

  localparam logic [4:0] DivLast = 5'(DelayW - 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FALLBACK_RATE = 3'd0,
    CFG_MIN_TX_RATE   = 3'd1,
    CFG_WARMUP_COUNT  = 3'd2,
    CFG_LATENCY_LIMIT = 3'd3,
    CFG_NODE_ID       = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_t;

endpackage

### rtl/feedback_rate_packet_pacer.sv
`timescale 1ns / 1ps

// Feedback-driven packet pacer.
// Input stream (s_axis_*): one word per tick or feedback report. tuser is the
// kind (0 tick, 1 feedback); tdata carries now_ns, fb_rate and fb_latency_ms.
// Output stream (m_axis_*): exactly one word per input word. tuser is the send
// flag; on a send tdata carries seq_no, the tick time and node_id, otherwise
// it is all zero.
// Config channel (cfg_*): always ready; indexes 0..4 select fallback_rate,
// min_tx_rate, warmup_count, latency_limit_ms, node_id. Other indexes are
// dropped. Write only while the block is idle.
// Timing: the result word is registered, so it appears in the cycle after
// the input word is taken; a tick needs no further work. A feedback word
// starts a bit-serial restoring divider (1e9 / rate, one quotient bit per
// cycle) that refreshes the inter-packet delay; it holds s_axis_tready low
// until the division ends, so no input word is taken meanwhile. Ticks run at
// one per cycle while no division runs and the output is drained.
// Reset (rst, synchronous): registers go to their defaults, the packet count
// and next-send time go to zero, the rate to 100/s with its delay preloaded.
// Stall: while a result word waits on m_axis_tready, no input word is taken.
module feedback_rate_packet_pacer (
  input  logic                         clk,
  input  logic                         rst,
  // config write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fbrp_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [fbrp_pkg::Word32W-1:0] cfg_data,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: now_ns[63:0], fb_rate[87:64], fb_latency_ms[119:88]
  input  logic [fbrp_pkg::InDataW-1:0] s_axis_tdata,
  // tuser: op[0]
  input  logic                         s_axis_tuser,
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: seq_no[31:0], sent_time_ns[95:32], packet_sender[127:96]
  output logic [fbrp_pkg::OutDataW-1:0] m_axis_tdata,
  // tuser: send[0]
  output logic                         m_axis_tuser
);
  import fbrp_pkg::*;

  // config registers
  logic [RateW-1:0]   fallback_rate;
  logic [RateW-1:0]   min_tx_rate;
  logic [Word32W-1:0] warmup_count;
  logic [Word32W-1:0] latency_limit_ms;
  logic [Word32W-1:0] node_id;

  // pacing state
  logic [Word32W-1:0] packets_sent;
  logic [TimeW-1:0]   next_send_time;
  logic [DelayW-1:0]  delay;

  // divider
  state_t             state;
  logic [4:0]         cnt;
  logic [RateW-1:0]   div_rate;   // never zero
  logic [RateW-1:0]   rem;
  logic [DelayW-1:0]  qd;         // dividend bits out the top, quotient bits in
  logic [RateW:0]     rem_sh;
  logic               q_bit;
  logic [RateW:0]     rem_sub;

  // input unpack
  logic               in_acc;
  logic [TimeW-1:0]   now_ns;
  logic [FbRateW-1:0] fb_rate;
  logic [Word32W-1:0] fb_latency_ms;
  logic               due;
  logic [RateW-1:0]   fb_rate_x2;
  logic [RateW-1:0]   new_rate;

  assign now_ns        = s_axis_tdata[63:0];
  assign fb_rate       = s_axis_tdata[87:64];
  assign fb_latency_ms = s_axis_tdata[119:88];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE) && (!m_axis_tvalid || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign due        = (next_send_time <= now_ns);
  assign fb_rate_x2 = {fb_rate, 1'b0};

  always_comb begin
    if (packets_sent <= warmup_count) begin
      new_rate = fallback_rate;
    end else if (fb_latency_ms >= latency_limit_ms) begin
      new_rate = fallback_rate;
    end else if (fb_rate_x2 < min_tx_rate) begin
      new_rate = min_tx_rate;
    end else begin
      new_rate = fb_rate_x2;
    end
  end

  // one restoring step per cycle
  assign rem_sh  = {rem, qd[DelayW-1]};
  assign rem_sub = rem_sh - {1'b0, div_rate};
  assign q_bit   = (rem_sh >= {1'b0, div_rate});

  always_ff @(posedge clk) begin
    if (rst) begin
      fallback_rate    <= FallbackRateRst;
      min_tx_rate      <= MinTxRateRst;
      warmup_count     <= WarmupCountRst;
      latency_limit_ms <= LatencyLimitRst;
      node_id          <= NodeIdRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FALLBACK_RATE: fallback_rate    <= cfg_data[RateW-1:0];
        CFG_MIN_TX_RATE:   min_tx_rate      <= cfg_data[RateW-1:0];
        CFG_WARMUP_COUNT:  warmup_count     <= cfg_data;
        CFG_LATENCY_LIMIT: latency_limit_ms <= cfg_data;
        CFG_NODE_ID:       node_id          <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      packets_sent   <= '0;
      next_send_time <= '0;
      delay          <= DelayRst;
      cnt            <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && !in_acc) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            m_axis_tvalid <= 1'b1;
            if (!s_axis_tuser) begin
              if (due) begin
                packets_sent   <= packets_sent + 32'd1;
                next_send_time <= now_ns + {{(TimeW-DelayW){1'b0}}, delay};
              end
            end else begin
              // new rate: kick the divider for its delay
              state <= ST_DIV;
              cnt   <= '0;
            end
          end
        end
        ST_DIV: begin
          cnt <= cnt + 5'd1;
          if (cnt == DivLast) begin
            delay <= {qd[DelayW-2:0], q_bit};
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      if (in_acc && s_axis_tuser) begin
        div_rate <= (new_rate == '0) ? RateW'(1) : new_rate;
        rem      <= '0;
        qd       <= NsPerSec;
      end
    end else begin
      rem <= q_bit ? rem_sub[RateW-1:0] : rem_sh[RateW-1:0];
      qd  <= {qd[DelayW-2:0], q_bit};
    end
    if (in_acc) begin
      if (!s_axis_tuser && due) begin
        m_axis_tuser <= 1'b1;
        m_axis_tdata <= {node_id, now_ns, packets_sent};
      end else begin
        m_axis_tuser <= 1'b0;
        m_axis_tdata <= '0;
      end
    end
  end

endmodule

### rtl/fbrp_checker.sv
`timescale 1ns / 1ps

module fbrp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [fbrp_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result word changed while stalled");

  // no send means an empty payload
  a_nosend_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("payload not zero on a no-send result");

  // input is held off while a result waits
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result stalled");

  // a feedback word starts the divider, which blocks input next cycle
  a_fb_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready)
    else $error("input ready right after feedback");

  // reset empties the output
  a_rst_clear: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind feedback_rate_packet_pacer fbrp_checker u_fbrp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
